/* hw/rtl/ubx_frame_receiver_top_assert.svh */
// Assertion macros for the frame receiver top level.
`ifndef UBX_FRAME_RECEIVER_TOP_ASSERT_SVH
`define UBX_FRAME_RECEIVER_TOP_ASSERT_SVH

// Check that the consequent holds whenever the antecedent holds.
`define UBXR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define UBXR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ubxr_pkg.sv */
// Package: constants, status codes and result type of the frame receiver.
`timescale 1ns / 1ps
package ubxr_pkg;

  localparam int RX_BUF_SIZE = 256;
  localparam int POS_W = $clog2(RX_BUF_SIZE);

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam int PAYLOAD_START  = 6;
  localparam int FRAME_OVERHEAD = 8;

  localparam logic [1:0] STAT_BUSY     = 2'd0;
  localparam logic [1:0] STAT_OK       = 2'd1;
  localparam logic [1:0] STAT_BAD_CK   = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW = 2'd3;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  byte_pos;
    logic        is_payload;
    logic [7:0]  msg_class;
    logic [7:0]  msg_ident;
    logic [15:0] payload_len;
    logic        frame_end;
    logic [1:0]  status;
  } result_t;

  function automatic logic [7:0] to_byte_pos(input pos_t pos);
    logic [POS_W+7:0] wide;
    wide = {8'h00, pos};
    return wide[7:0];
  endfunction

endpackage

/* hw/rtl/ubxr_stream_if.sv */
// Interfaces: received byte channel and result item channel.
`timescale 1ns / 1ps
interface ubxr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ubxr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [7:0]  byte_pos;
  logic        is_payload;
  logic [7:0]  msg_class;
  logic [7:0]  msg_ident;
  logic [15:0] payload_len;
  logic        frame_end;
  logic [1:0]  status;

  modport source (output valid, output data_byte, output byte_pos, output is_payload,
                  output msg_class, output msg_ident, output payload_len,
                  output frame_end, output status, input ready);
  modport sink (input valid, input data_byte, input byte_pos, input is_payload,
                input msg_class, input msg_ident, input payload_len,
                input frame_end, input status, output ready);
endinterface

/* hw/rtl/ubx_frame_receiver_top.sv */
// Top level of the UBX frame receiver: input register, frame core, result register.
//
// Usage:
//   in_ch carries one received serial byte per item (rx_byte). out_ch carries
//   one result item per input item: the echoed byte, its frame position, a
//   payload flag, the latched class, id and payload length, a frame end flag
//   and a status code (in progress or dropped, ok, bad checksum, overflow).
//   Both channels take an item on a clock edge with valid and ready high.
//   An accepted item sits in the input register, and the frame logic loads
//   the result register from it once that register is empty or being taken.
//   Throughput is one item per cycle while out_ch does not stall; the checksum
//   and position update are combinational between the input register and the
//   result register.
//   A stalled result holds in the result register; the input register keeps
//   accepting until it too is full, and then in_ch.ready drops.
//   Reset (rst_n low, synchronous) holds in_ch.ready low, empties both
//   registers and returns the frame tracker to sync hunt with zero length,
//   sums, class and id.
`timescale 1ns / 1ps
`include "ubx_frame_receiver_top_assert.svh"
module ubx_frame_receiver_top (
  input logic clk,
  input logic rst_n,
  ubxr_in_if.sink    in_ch,
  ubxr_out_if.source out_ch
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [7:0]        s1_byte_r;
  logic              out_valid_r, out_valid_nxt;
  ubxr_pkg::result_t out_data_r;
  ubxr_pkg::result_t core_result;
  logic              s1_move;
  logic              in_acc;

  assign s1_move     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!s1_valid_r || s1_move);
  assign in_acc      = in_ch.valid && in_ch.ready;

  ubxr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_move),
    .rx_byte(s1_byte_r),
    .result (core_result)
  );

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_move ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.rx_byte;
    end
    if (s1_move) begin
      out_data_r <= core_result;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_byte   = out_data_r.data_byte;
  assign out_ch.byte_pos    = out_data_r.byte_pos;
  assign out_ch.is_payload  = out_data_r.is_payload;
  assign out_ch.msg_class   = out_data_r.msg_class;
  assign out_ch.msg_ident   = out_data_r.msg_ident;
  assign out_ch.payload_len = out_data_r.payload_len;
  assign out_ch.frame_end   = out_data_r.frame_end;
  assign out_ch.status      = out_data_r.status;

  `UBXR_ASSERT_IMPLY(a_end_status, out_valid_r,
    out_data_r.frame_end == (out_data_r.status != ubxr_pkg::STAT_BUSY),
    "frame end and status disagree")
  `UBXR_ASSERT_NEXT(a_s1_hold, s1_valid_r && out_valid_r && !out_ch.ready,
    s1_valid_r && out_valid_r, "item lost while result stalled")
  `UBXR_ASSERT_IMPLY(a_ready_full, !in_ch.ready, s1_valid_r && out_valid_r,
    "input stalled with a free register")

endmodule

/* hw/rtl/ubxr_core.sv */
// Frame tracking core: sync hunt, header latch, Fletcher checksum, end detection.
`timescale 1ns / 1ps
module ubxr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output ubxr_pkg::result_t result
);

  ubxr_pkg::pos_t pos_r, pos_nxt;
  logic [15:0] length_r, length_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  ident_r, ident_nxt;
  logic [7:0]  ck_a_r, ck_a_nxt;

  logic        sync_miss;
  logic [15:0] len_eff;
  logic [16:0] pos_ext;
  logic [16:0] len_ext;
  logic        in_sum;
  logic        at_ck_a;
  logic        at_end;
  logic        at_overflow;
  logic        restart;
  logic        ck_ok;

  always_comb begin
    pos_ext = 17'(pos_r);
    sync_miss = ((pos_r == ubxr_pkg::pos_t'(0)) && (rx_byte != ubxr_pkg::SYNC_FIRST)) ||
                ((pos_r == ubxr_pkg::pos_t'(1)) && (rx_byte != ubxr_pkg::SYNC_SECOND));

    class_nxt  = (pos_r == ubxr_pkg::pos_t'(2)) ? rx_byte : class_r;
    ident_nxt  = (pos_r == ubxr_pkg::pos_t'(3)) ? rx_byte : ident_r;
    length_nxt = length_r;
    if (pos_r == ubxr_pkg::pos_t'(4)) begin
      length_nxt = {8'h00, rx_byte};
    end else if (pos_r == ubxr_pkg::pos_t'(5)) begin
      length_nxt = length_r | {rx_byte, 8'h00};
    end

    len_eff = (pos_ext >= 17'd5) ? length_nxt : 16'h0000;
    len_ext = 17'(len_eff);

    in_sum  = (pos_ext >= 17'd2) &&
              (pos_ext < len_ext + 17'(ubxr_pkg::PAYLOAD_START));
    at_ck_a = (pos_ext == len_ext + 17'(ubxr_pkg::PAYLOAD_START));
    at_end  = (pos_ext == len_ext + 17'(ubxr_pkg::FRAME_OVERHEAD - 1));
    at_overflow = !at_end && (pos_r == ubxr_pkg::pos_t'(ubxr_pkg::RX_BUF_SIZE - 1));

    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    ck_a_nxt  = ck_a_r;
    if (in_sum) begin
      sum_a_nxt = sum_a_r + rx_byte;
      sum_b_nxt = sum_b_r + sum_a_nxt;
    end else if (at_ck_a) begin
      ck_a_nxt = rx_byte;
    end

    ck_ok = (sum_a_r == ck_a_r) && (sum_b_r == rx_byte);
    pos_nxt = pos_r + ubxr_pkg::pos_t'(1);

    result.data_byte   = rx_byte;
    result.byte_pos    = ubxr_pkg::to_byte_pos(pos_r);
    result.is_payload  = (pos_ext >= 17'(ubxr_pkg::PAYLOAD_START)) &&
                         (pos_ext < len_ext + 17'(ubxr_pkg::PAYLOAD_START));
    result.msg_class   = class_nxt;
    result.msg_ident   = ident_nxt;
    result.payload_len = length_nxt;
    result.frame_end   = at_end || at_overflow;
    result.status      = at_end ? (ck_ok ? ubxr_pkg::STAT_OK : ubxr_pkg::STAT_BAD_CK) :
                         (at_overflow ? ubxr_pkg::STAT_OVERFLOW : ubxr_pkg::STAT_BUSY);

    // drop a byte that breaks the sync pair
    if (sync_miss) begin
      class_nxt          = class_r;
      ident_nxt          = ident_r;
      result.is_payload  = 1'b0;
      result.msg_class   = class_r;
      result.msg_ident   = ident_r;
      result.payload_len = 16'h0000;
      result.frame_end   = 1'b0;
      result.status      = ubxr_pkg::STAT_BUSY;
    end

    restart = sync_miss || at_end || at_overflow;
    if (restart) begin
      pos_nxt    = '0;
      length_nxt = 16'h0000;
      sum_a_nxt  = 8'h00;
      sum_b_nxt  = 8'h00;
      ck_a_nxt   = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      length_r <= 16'h0000;
      sum_a_r  <= 8'h00;
      sum_b_r  <= 8'h00;
      class_r  <= 8'h00;
      ident_r  <= 8'h00;
      ck_a_r   <= 8'h00;
    end else if (step) begin
      pos_r    <= pos_nxt;
      length_r <= length_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      class_r  <= class_nxt;
      ident_r  <= ident_nxt;
      ck_a_r   <= ck_a_nxt;
    end
  end

endmodule
